// ----- hw/rtl/first_fit_heap_allocator_top_macros.svh -----
// assertion macros shared by the heap allocator rtl
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH

// condition implies consequence in the same cycle
`define FFHA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ffha_pkg.sv -----
// types and constants of the first-fit heap allocator
`default_nettype none

package ffha_pkg;

    localparam int HEAP_BYTES   = 1024;
    localparam int HEADER_BYTES = 24;

    // fixed field widths of the request and response
    localparam int REQ_W  = 12;
    localparam int DOFF_W = 11;
    localparam int DOUT_W = 10;
    localparam int MRG_W  = 6;

    // block offsets and block sizes inside the heap
    localparam int OFF_W  = $clog2(HEAP_BYTES);
    localparam int SIZE_W = OFF_W + 1;
    localparam int SUM_W  = ((OFF_W > REQ_W) ? OFF_W : REQ_W) + 2;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_kind;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_ZERO_SIZE    = 3'd1,
        ST_NO_SPACE     = 3'd2,
        ST_BAD_OFFSET   = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } t_status;

    typedef struct packed {
        t_req_kind           req_type;
        logic [REQ_W-1:0]    req_size;
        logic [DOFF_W-1:0]   data_offset_in;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [DOUT_W-1:0]   data_offset_out;
        logic [MRG_W-1:0]    merge_count;
    } t_rsp;

    // one block header as kept in the header memory
    typedef struct packed {
        logic                is_free;
        logic [SIZE_W-1:0]   size;
    } t_hdr;

    localparam int HDR_W = $bits(t_hdr);

endpackage

`default_nettype wire

// ----- hw/rtl/first_fit_heap_allocator_top.sv -----
// top level of the first-fit heap allocator with free-block coalescing
//
//  channel   direction  handshake                    payload
//  request   in         i_req_valid / o_req_stall    i_req  (t_req)
//  response  out        o_rsp_valid / i_rsp_stall    o_rsp  (t_rsp)
//
// an allocation walks the blocks from offset zero until one fits; a free walks
// to its block and then walks the heap again from offset zero to coalesce; every
// block visited costs one read of the header memory (one registered read port), merges included
// after reset the block writes the initial free header
// and keeps o_req_stall high meanwhile
// a finished response moves into the output register, so the next request
// is taken while the response still waits out a stall downstream
`default_nettype none

`include "first_fit_heap_allocator_top_macros.svh"

module first_fit_heap_allocator_top
    import ffha_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_stall,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_stall,
    output t_rsp      o_rsp
);

    // header memory port between walker and ram
    logic               ram_we;
    logic [OFF_W-1:0]   ram_waddr;
    logic [HDR_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [OFF_W-1:0]   ram_raddr;
    logic [HDR_W-1:0]   ram_rdata;

    // finished result from the walker
    logic               res_valid;
    t_rsp               res;
    logic               res_take;

    // output register
    logic               r_out_valid, n_out_valid;
    t_rsp               r_out;

    ffha_ram #(
        .WIDTH (HDR_W),
        .DEPTH (HEAP_BYTES)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_req_stall (o_req_stall),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // load when the output register is empty or its transfer completes now
    assign res_take = res_valid && (!r_out_valid || !i_rsp_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_take) begin
            n_out_valid = 1'b1;
        end else if (!i_rsp_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    `FFHA_ASSERT_NEXT(a_res_kept, i_clk, i_rst_n, res_valid && !res_take, res_valid, "walker result dropped before transfer")

endmodule

`default_nettype wire

// ----- hw/rtl/ffha_ram.sv -----
// generic single-clock ram, one write port and one registered read port
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ffha_ctrl.sv -----
// block walker: allocate, free and coalesce over the header memory
`default_nettype none

`include "first_fit_heap_allocator_top_macros.svh"

module ffha_ctrl
    import ffha_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire t_req              i_req,
    output logic                   o_req_stall,
    output logic                   o_res_valid,
    output t_rsp                   o_res,
    input  wire logic              i_res_take,
    output logic                   o_ram_we,
    output logic [OFF_W-1:0]       o_ram_waddr,
    output logic [HDR_W-1:0]       o_ram_wdata,
    output logic                   o_ram_re,
    output logic [OFF_W-1:0]       o_ram_raddr,
    input  wire logic [HDR_W-1:0]  i_ram_rdata
);

    typedef enum logic [7:0] {
        S_INIT     = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_WALK     = 8'b0000_0100,
        S_SPLIT    = 8'b0000_1000,
        S_CO_START = 8'b0001_0000,
        S_CO_CUR   = 8'b0010_0000,
        S_CO_NXT   = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    localparam logic [SUM_W-1:0] HDR_S  = SUM_W'(HEADER_BYTES);
    localparam logic [SUM_W-1:0] HEAP_S = SUM_W'(HEAP_BYTES);

    t_state              r_state, n_state;
    t_req_kind           r_kind, n_kind;
    logic [REQ_W-1:0]    r_size, n_size;
    logic [DOFF_W-1:0]   r_doff, n_doff;
    logic [OFF_W-1:0]    r_off, n_off;
    logic [OFF_W-1:0]    r_nx, n_nx;
    logic [SIZE_W-1:0]   r_cur_size, n_cur_size;
    logic [MRG_W-1:0]    r_merges, n_merges;
    t_status             r_status, n_status;
    logic [DOUT_W-1:0]   r_dout, n_dout;

    t_hdr                hdr;
    t_hdr                wr_hdr;
    logic [SUM_W-1:0]    walk_nx;
    logic [SUM_W-1:0]    skip_nx;
    logic [SUM_W-1:0]    merged;
    logic [SUM_W-1:0]    merged_nx;
    logic [SUM_W-1:0]    split_at;
    logic [SUM_W-1:0]    split_rem;
    logic [SUM_W-1:0]    data_at;
    logic                fits;
    logic                do_split;

    assign hdr       = t_hdr'(i_ram_rdata);
    assign walk_nx   = SUM_W'(r_off) + HDR_S + SUM_W'(hdr.size);
    assign skip_nx   = SUM_W'(r_nx) + HDR_S + SUM_W'(hdr.size);
    assign merged    = SUM_W'(r_cur_size) + SUM_W'(hdr.size) + HDR_S;
    assign merged_nx = SUM_W'(r_off) + HDR_S + merged;
    assign split_at  = SUM_W'(r_off) + HDR_S + SUM_W'(r_size);
    assign split_rem = SUM_W'(hdr.size) - SUM_W'(r_size) - HDR_S;
    assign data_at   = SUM_W'(r_off) + HDR_S;
    assign fits      = hdr.is_free && (SUM_W'(hdr.size) >= SUM_W'(r_size));
    assign do_split  = SUM_W'(hdr.size) > (SUM_W'(r_size) + HDR_S);

    assign o_ram_wdata = wr_hdr;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_size      = r_size;
        n_doff      = r_doff;
        n_off       = r_off;
        n_nx        = r_nx;
        n_cur_size  = r_cur_size;
        n_merges    = r_merges;
        n_status    = r_status;
        n_dout      = r_dout;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_off;
        wr_hdr      = '0;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_off;

        unique case (r_state)
            S_INIT: begin
                // heap starts as one free block at offset zero
                o_ram_we       = 1'b1;
                o_ram_waddr    = '0;
                wr_hdr.is_free = 1'b1;
                wr_hdr.size    = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
                n_state        = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_kind   = i_req.req_type;
                    n_size   = i_req.req_size;
                    n_doff   = i_req.data_offset_in;
                    n_off    = '0;
                    n_merges = '0;
                    n_dout   = '0;
                    n_status = ST_OK;
                    if (i_req.req_type == REQ_ALLOC && i_req.req_size == '0) begin
                        n_status = ST_ZERO_SIZE;
                        n_state  = S_DONE;
                    end else if (i_req.req_type == REQ_FREE &&
                                 SUM_W'(i_req.data_offset_in) >= HEAP_S) begin
                        n_status = ST_BAD_OFFSET;
                        n_state  = S_DONE;
                    end else begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = '0;
                        n_state     = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_kind == REQ_ALLOC) begin
                    if (fits) begin
                        n_dout   = DOUT_W'(data_at);
                        n_status = ST_OK;
                        if (do_split) begin
                            // remainder becomes a new free block
                            o_ram_we       = 1'b1;
                            o_ram_waddr    = OFF_W'(split_at);
                            wr_hdr.is_free = 1'b1;
                            wr_hdr.size    = SIZE_W'(split_rem);
                            n_state        = S_SPLIT;
                        end else begin
                            o_ram_we       = 1'b1;
                            wr_hdr.is_free = 1'b0;
                            wr_hdr.size    = hdr.size;
                            n_state        = S_DONE;
                        end
                    end else if (walk_nx >= HEAP_S) begin
                        n_status = ST_NO_SPACE;
                        n_state  = S_DONE;
                    end else begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = OFF_W'(walk_nx);
                        n_off       = OFF_W'(walk_nx);
                    end
                end else begin
                    if (data_at == SUM_W'(r_doff)) begin
                        if (hdr.is_free) begin
                            n_status = ST_ALREADY_FREE;
                            n_state  = S_DONE;
                        end else begin
                            o_ram_we       = 1'b1;
                            wr_hdr.is_free = 1'b1;
                            wr_hdr.size    = hdr.size;
                            n_status       = ST_OK;
                            n_state        = S_CO_START;
                        end
                    end else if (walk_nx >= HEAP_S) begin
                        n_status = ST_BAD_OFFSET;
                        n_state  = S_DONE;
                    end else begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = OFF_W'(walk_nx);
                        n_off       = OFF_W'(walk_nx);
                    end
                end
            end
            S_SPLIT: begin
                o_ram_we       = 1'b1;
                wr_hdr.is_free = 1'b0;
                wr_hdr.size    = SIZE_W'(r_size);
                n_state        = S_DONE;
            end
            S_CO_START: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = '0;
                n_off       = '0;
                n_state     = S_CO_CUR;
            end
            S_CO_CUR: begin
                if (walk_nx >= HEAP_S) begin
                    n_state = S_DONE;
                end else begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = OFF_W'(walk_nx);
                    if (hdr.is_free) begin
                        n_nx       = OFF_W'(walk_nx);
                        n_cur_size = hdr.size;
                        n_state    = S_CO_NXT;
                    end else begin
                        n_off = OFF_W'(walk_nx);
                    end
                end
            end
            S_CO_NXT: begin
                if (hdr.is_free) begin
                    // absorb the follower into the current free block
                    o_ram_we       = 1'b1;
                    wr_hdr.is_free = 1'b1;
                    wr_hdr.size    = SIZE_W'(merged);
                    n_cur_size     = SIZE_W'(merged);
                    if (r_merges != '1) begin
                        n_merges = r_merges + MRG_W'(1);
                    end
                    if (merged_nx >= HEAP_S) begin
                        n_state = S_DONE;
                    end else begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = OFF_W'(merged_nx);
                        n_nx        = OFF_W'(merged_nx);
                    end
                end else begin
                    // follower is allocated, step past it
                    if (skip_nx >= HEAP_S) begin
                        n_state = S_DONE;
                    end else begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = OFF_W'(skip_nx);
                        n_off       = OFF_W'(skip_nx);
                        n_state     = S_CO_CUR;
                    end
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
        r_kind     <= n_kind;
        r_size     <= n_size;
        r_doff     <= n_doff;
        r_off      <= n_off;
        r_nx       <= n_nx;
        r_cur_size <= n_cur_size;
        r_merges   <= n_merges;
        r_status   <= n_status;
        r_dout     <= n_dout;
    end

    assign o_req_stall           = (r_state != S_IDLE);
    assign o_res_valid           = (r_state == S_DONE);
    assign o_res.status          = r_status;
    assign o_res.data_offset_out = r_dout;
    assign o_res.merge_count     = r_merges;

    `FFHA_ASSERT_SAME(a_no_rw_clash, i_clk, i_rst_n, o_ram_we && o_ram_re, o_ram_waddr != o_ram_raddr, "header write and read hit the same entry")
    `FFHA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, (r_state == S_IDLE) && i_req_valid, r_state != S_IDLE, "accepted request did not start")
    `FFHA_ASSERT_SAME(a_err_fields_zero, i_clk, i_rst_n, o_res_valid && (r_status != ST_OK), (r_dout == '0) && (r_merges == '0), "error result carries data")

endmodule

`default_nettype wire
